[rtl/core/tmr_pkg.sv]
`timescale 1ns / 1ps

package tmr_pkg;

   localparam int DEF_MAX_STEPS  = 10;
   localparam int DEF_TAPE_CELLS = 23;

   localparam int CNT_W = 4;
   localparam logic [CNT_W-1:0] COUNT_MAX = '1;

   localparam int RULE_W     = 4;
   localparam int RULE_HALT  = 3;
   localparam int RULE_WRITE = 2;
   localparam int RULE_RIGHT = 1;
   localparam int RULE_NEXT  = 0;

   typedef enum logic [1:0] {
      FLAG_NONE = 2'd0,
      FLAG_TIE  = 2'd1,
      FLAG_NEW  = 2'd2
   } flag_type;

   typedef struct packed {
      logic [RULE_W-1:0] rule_a_on_zero;
      logic [RULE_W-1:0] rule_a_on_one;
      logic [RULE_W-1:0] rule_b_on_zero;
      logic [RULE_W-1:0] rule_b_on_one;
   } req_type;

   typedef struct packed {
      logic             halted;
      logic [CNT_W-1:0] step_count;
      logic [CNT_W-1:0] ones_count;
      logic [1:0]       steps_record_flag;
      logic [1:0]       ones_record_flag;
      logic [CNT_W-1:0] best_step_count;
      logic [CNT_W-1:0] best_ones_count;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic shift;
      logic move_right;
   } tape_ctrl_type;

endpackage

[rtl/core/tmr_cell.sv]
`timescale 1ns / 1ps

module tmr_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  tmr_pkg::tape_ctrl_type ctrl,
   input  logic                  from_left,
   input  logic                  from_right,
   output logic                  bit_out
);
   import tmr_pkg::*;

   logic bit_ff;
   logic bit_in;

   assign bit_out = bit_ff;

   always_comb begin
      bit_in = bit_ff;
      if (ctrl.clear) begin
         bit_in = 1'b0;
      end else if (ctrl.shift) begin
         bit_in = ctrl.move_right ? from_right : from_left;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff <= 1'b0;
      end else begin
         bit_ff <= bit_in;
      end
   end

endmodule

[rtl/core/tmr_tape.sv]
`timescale 1ns / 1ps

module tmr_tape #(
   parameter int TAPE_CELLS = tmr_pkg::DEF_TAPE_CELLS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tmr_pkg::tape_ctrl_type ctrl,
   input  logic                   wr_bit,
   output logic                   head_bit
);
   import tmr_pkg::*;

   localparam int HEAD = TAPE_CELLS / 2;

   logic [TAPE_CELLS-1:0] cell_q;
   logic [TAPE_CELLS-1:0] cell_out;

   // head cell hands the written bit to its neighbor as the tape moves
   always_comb begin
      cell_out = cell_q;
      if (ctrl.shift) begin
         cell_out[HEAD] = wr_bit;
      end
   end

   // ring of cells, head fixed at the middle, tape rotates under it
   for (genvar i = 0; i < TAPE_CELLS; i++) begin : g_cell
      localparam int LEFT  = (i + TAPE_CELLS - 1) % TAPE_CELLS;
      localparam int RIGHT = (i + 1) % TAPE_CELLS;
      tmr_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .from_left  (cell_out[LEFT]),
         .from_right (cell_out[RIGHT]),
         .bit_out    (cell_q[i])
      );
   end

   assign head_bit = cell_q[HEAD];

endmodule

[rtl/core/turing_machine_run_engine.sv]
`timescale 1ns / 1ps

// Runs one two-state, two-symbol machine program per request word on a
// circular tape of TAPE_CELLS one-bit cells that rotates under a fixed head,
// one transition per cycle. A run stays in the run loop until it halts or
// stops at the step limit; then the response word is delivered and the tape
// cleared together, and the engine goes idle to take the next word, so no
// word is taken while a run is in progress. The ones count is kept as the
// head writes, so no pass over the tape is needed. The response sits in an
// output register; a run that ends while it is still held waits there.
module turing_machine_run_engine #(
   parameter int MAX_STEPS  = tmr_pkg::DEF_MAX_STEPS,
   parameter int TAPE_CELLS = tmr_pkg::DEF_TAPE_CELLS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tmr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tmr_pkg::rsp_type rsp_data
);
   import tmr_pkg::*;

   localparam int SW = $clog2(MAX_STEPS + 3);
   localparam int OW = $clog2(TAPE_CELLS + 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   req_type          rules_ff, rules_in;
   logic             mstate_ff, mstate_in;
   logic [SW-1:0]    steps_ff, steps_in;
   logic [OW-1:0]    ones_ff, ones_in;
   logic             halted_ff, halted_in;
   logic [CNT_W-1:0] rec_steps_ff, rec_steps_in;
   logic [CNT_W-1:0] rec_ones_ff, rec_ones_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   tape_ctrl_type    tape_ctrl;
   logic             head_bit;
   logic [RULE_W-1:0] rule;
   logic             out_free;
   logic             step_go;
   logic [CNT_W-1:0] steps_sat, ones_sat;
   flag_type         sflag, oflag;

   tmr_tape #(
      .TAPE_CELLS (TAPE_CELLS)
   ) u_tape (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (tape_ctrl),
      .wr_bit   (rule[RULE_WRITE]),
      .head_bit (head_bit)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      case ({mstate_ff, head_bit})
         2'b00:   rule = rules_ff.rule_a_on_zero;
         2'b01:   rule = rules_ff.rule_a_on_one;
         2'b10:   rule = rules_ff.rule_b_on_zero;
         2'b11:   rule = rules_ff.rule_b_on_one;
         default: rule = rules_ff.rule_a_on_zero;
      endcase
   end

   assign step_go = (state_ff == ST_RUN) && !rule[RULE_HALT]
                    && !(steps_ff > SW'(MAX_STEPS));

   always_comb begin
      tape_ctrl.clear      = (state_ff == ST_DONE) && out_free;
      tape_ctrl.shift      = step_go;
      tape_ctrl.move_right = rule[RULE_RIGHT];
   end

   assign steps_sat = (32'(steps_ff) > 32'(COUNT_MAX)) ? COUNT_MAX : CNT_W'(steps_ff);
   assign ones_sat  = (32'(ones_ff) > 32'(COUNT_MAX)) ? COUNT_MAX : CNT_W'(ones_ff);

   always_comb begin
      sflag = FLAG_NONE;
      oflag = FLAG_NONE;
      if (halted_ff) begin
         if (steps_sat > rec_steps_ff) begin
            sflag = FLAG_NEW;
         end else if (steps_sat == rec_steps_ff) begin
            sflag = FLAG_TIE;
         end
         if (ones_sat > rec_ones_ff) begin
            oflag = FLAG_NEW;
         end else if (ones_sat == rec_ones_ff) begin
            oflag = FLAG_TIE;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      rules_in     = rules_ff;
      mstate_in    = mstate_ff;
      steps_in     = steps_ff;
      ones_in      = ones_ff;
      halted_in    = halted_ff;
      rec_steps_in = rec_steps_ff;
      rec_ones_in  = rec_ones_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               rules_in  = req_data;
               mstate_in = 1'b0;
               steps_in  = '0;
               ones_in   = '0;
               halted_in = 1'b0;
               state_in  = ST_RUN;
            end
         end
         ST_RUN: begin
            if (rule[RULE_HALT]) begin
               steps_in  = steps_ff + SW'(1);
               halted_in = 1'b1;
               state_in  = ST_DONE;
            end else if (steps_ff > SW'(MAX_STEPS)) begin
               state_in = ST_DONE;
            end else begin
               steps_in  = steps_ff + SW'(1);
               mstate_in = rule[RULE_NEXT];
               ones_in   = ones_ff + OW'(rule[RULE_WRITE]) - OW'(head_bit);
            end
         end
         ST_DONE: begin
            if (out_free) begin
               if (sflag == FLAG_NEW) begin
                  rec_steps_in = steps_sat;
               end
               if (oflag == FLAG_NEW) begin
                  rec_ones_in = ones_sat;
               end
               rsp_in.halted            = halted_ff;
               rsp_in.step_count        = steps_sat;
               rsp_in.ones_count        = halted_ff ? ones_sat : '0;
               rsp_in.steps_record_flag = sflag;
               rsp_in.ones_record_flag  = oflag;
               rsp_in.best_step_count   = (sflag == FLAG_NEW) ? steps_sat : rec_steps_ff;
               rsp_in.best_ones_count   = (oflag == FLAG_NEW) ? ones_sat : rec_ones_ff;
               rsp_valid_in             = 1'b1;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mstate_ff    <= 1'b0;
         steps_ff     <= '0;
         ones_ff      <= '0;
         halted_ff    <= 1'b0;
         rec_steps_ff <= '0;
         rec_ones_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mstate_ff    <= mstate_in;
         steps_ff     <= steps_in;
         ones_ff      <= ones_in;
         halted_ff    <= halted_in;
         rec_steps_ff <= rec_steps_in;
         rec_ones_ff  <= rec_ones_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rules_ff <= rules_in;
      rsp_ff   <= rsp_in;
   end

endmodule

[bench/tb_turing_machine_run_engine.sv]
`timescale 1ns / 1ps

class machine_run_checker;
   tmr_pkg::rsp_type expected_runs[$];
   logic [tmr_pkg::CNT_W-1:0] best_steps;
   logic [tmr_pkg::CNT_W-1:0] best_ones;
   int errors;
   int runs_checked;
   int runs_halted;
   int runs_capped;

   function new();
      best_steps = '0;
      best_ones = '0;
      errors = 0;
      runs_checked = 0;
      runs_halted = 0;
      runs_capped = 0;
   endfunction

   function logic [tmr_pkg::CNT_W-1:0] clamp_count(int v);
      return (v > int'(tmr_pkg::COUNT_MAX)) ? tmr_pkg::COUNT_MAX : v[tmr_pkg::CNT_W-1:0];
   endfunction

   function tmr_pkg::flag_type grade(logic [tmr_pkg::CNT_W-1:0] v,
                                     inout logic [tmr_pkg::CNT_W-1:0] best);
      if (v > best) begin
         best = v;
         return tmr_pkg::FLAG_NEW;
      end
      if (v == best)
         return tmr_pkg::FLAG_TIE;
      return tmr_pkg::FLAG_NONE;
   endfunction

   // run the program on a blank tape and queue the response it should give
   function void note_program(tmr_pkg::req_type p);
      logic [tmr_pkg::RULE_W-1:0] rules [4];
      logic [tmr_pkg::DEF_TAPE_CELLS-1:0] tape;
      logic [tmr_pkg::RULE_W-1:0] r;
      int head;
      int st;
      int steps;
      bit halted_run;
      bit done;
      tmr_pkg::rsp_type e;
      rules[0] = p.rule_a_on_zero;
      rules[1] = p.rule_a_on_one;
      rules[2] = p.rule_b_on_zero;
      rules[3] = p.rule_b_on_one;
      tape = '0;
      head = tmr_pkg::DEF_TAPE_CELLS / 2;
      st = 0;
      steps = 0;
      halted_run = 1'b0;
      done = 1'b0;
      while (!done) begin
         r = rules[st * 2 + int'(tape[head])];
         if (r[tmr_pkg::RULE_HALT]) begin
            steps++;
            halted_run = 1'b1;
            done = 1'b1;
         end else if (steps > tmr_pkg::DEF_MAX_STEPS) begin
            done = 1'b1;
         end else begin
            tape[head] = r[tmr_pkg::RULE_WRITE];
            if (r[tmr_pkg::RULE_RIGHT])
               head = (head + 1 >= tmr_pkg::DEF_TAPE_CELLS) ? 0 : head + 1;
            else
               head = (head == 0) ? tmr_pkg::DEF_TAPE_CELLS - 1 : head - 1;
            st = int'(r[tmr_pkg::RULE_NEXT]);
            steps++;
         end
      end
      e = '0;
      e.halted = halted_run;
      e.step_count = clamp_count(steps);
      if (halted_run) begin
         e.ones_count = clamp_count($countones(tape));
         e.steps_record_flag = grade(e.step_count, best_steps);
         e.ones_record_flag = grade(e.ones_count, best_ones);
      end
      e.best_step_count = best_steps;
      e.best_ones_count = best_ones;
      expected_runs.insert(expected_runs.size(), e);
   endfunction

   function void compare_field(string name, int exp_v, int got_v);
      if (exp_v != got_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
      end
   endfunction

   function void check_run(tmr_pkg::rsp_type got);
      tmr_pkg::rsp_type e;
      if (expected_runs.size() == 0) begin
         errors++;
         $display("%0t: response word with no program pending, expected none, got %h",
                  $time, got);
         return;
      end
      e = expected_runs.pop_front();
      runs_checked++;
      if (e.halted)
         runs_halted++;
      else
         runs_capped++;
      compare_field("halted", int'(e.halted), int'(got.halted));
      compare_field("step_count", int'(e.step_count), int'(got.step_count));
      compare_field("ones_count", int'(e.ones_count), int'(got.ones_count));
      compare_field("steps_record_flag", int'(e.steps_record_flag),
                    int'(got.steps_record_flag));
      compare_field("ones_record_flag", int'(e.ones_record_flag),
                    int'(got.ones_record_flag));
      compare_field("best_step_count", int'(e.best_step_count), int'(got.best_step_count));
      compare_field("best_ones_count", int'(e.best_ones_count), int'(got.best_ones_count));
   endfunction

   function int pending();
      return expected_runs.size();
   endfunction
endclass

module tb_turing_machine_run_engine;
   import tmr_pkg::*;

   localparam int RANDOM_ITEMS = 1500;
   localparam int HOLD_AT = 500;
   localparam int DRAIN_AT = 1000;
   localparam int LONG_HOLD = 300;
   localparam int SETTLE_CYCLES = 3 * (DEF_MAX_STEPS + 4);
   localparam int CYCLE_LIMIT = 600000;
   localparam int NUM_DIRECTED = 20;

   localparam logic [15:0] DIRECTED [NUM_DIRECTED] = '{
      16'h8888, 16'hFFFF, 16'h0000, 16'h7548, 16'h6666,
      16'h7888, 16'h3888, 16'h5F00, 16'h9000, 16'hA111,
      16'hB222, 16'hC333, 16'hD444, 16'hE555, 16'h0F0F,
      16'h7F4F, 16'h1234, 16'h7C49, 16'h4F9F, 16'h2FFF
   };

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   machine_run_checker runs;
   int cycles = 0;
   int hold_asks = 0;

   turing_machine_run_engine u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         runs.check_run(rsp_data);
   end

   // receiver stall pattern, with a long hold-off on request
   initial begin : receiver
      stall_mode_type mode;
      int left;
      int hold_left;
      int hold_seen;
      int tick;
      mode = STALL_NONE;
      left = 0;
      hold_left = 0;
      hold_seen = 0;
      tick = 0;
      forever begin
         @(negedge clock);
         tick++;
         if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (left == 0) begin
               mode = stall_mode_type'($urandom_range(0, 3));
               left = $urandom_range(10, 80);
            end
            left--;
            case (mode)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 99) < 25);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 99) < 75);
               default:     rsp_stall <= ((tick % 7) < 3);
            endcase
         end
      end
   end

   function automatic req_type make_program();
      logic [15:0] bits;
      int slot;
      if ($urandom_range(0, 99) < 35)
         return req_type'(16'($urandom_range(0, 16'hFFFF)));
      // well-formed: non-halting rules with one or two halt rules among them
      bits = 16'($urandom_range(0, 16'hFFFF)) & 16'h7777;
      slot = $urandom_range(0, 3);
      bits[slot * 4 + RULE_HALT] = 1'b1;
      if ($urandom_range(0, 99) < 20)
         bits[$urandom_range(0, 3) * 4 + RULE_HALT] = 1'b1;
      return req_type'(bits);
   endfunction

   task automatic send_word(input req_type w);
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_stall);
      runs.note_program(w);
      @(negedge clock);
   endtask

   task automatic sender_gap();
      int gap;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 35)
         gap = 0;
      else if (pick < 92)
         gap = $urandom_range(1, 8);
      else
         gap = $urandom_range(12, 40);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   initial begin : stimulus
      int sent;
      int burst;
      bit held;
      bit drained;
      runs = new();
      sent = 0;
      held = 1'b0;
      drained = 1'b0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(negedge clock);

      for (int i = 0; i < NUM_DIRECTED; i++) begin
         send_word(req_type'(DIRECTED[i]));
         if (i % 5 == 4)
            sender_gap();
      end

      while (sent < RANDOM_ITEMS) begin
         if (!held && sent >= HOLD_AT) begin
            held = 1'b1;
            hold_asks++;
         end
         if (!drained && sent >= DRAIN_AT) begin
            drained = 1'b1;
            req_valid <= 1'b0;
            @(negedge clock);
            while (runs.pending() != 0) @(negedge clock);
         end
         burst = $urandom_range(1, 24);
         repeat (burst) begin
            send_word(make_program());
            sent++;
         end
         sender_gap();
      end

      req_valid <= 1'b0;
      while (runs.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("checked %0d programs: %0d halted, %0d hit the step limit",
               runs.runs_checked, runs.runs_halted, runs.runs_capped);
      $display("final records: %0d steps, %0d ones", runs.best_steps, runs.best_ones);
      if (runs.errors == 0 && runs.pending() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule

[filelist.f]
rtl/core/tmr_pkg.sv
rtl/core/tmr_cell.sv
rtl/core/tmr_tape.sv
rtl/core/turing_machine_run_engine.sv
bench/tb_turing_machine_run_engine.sv
